// File: hdl/owbm_pkg.sv
package owbm_pkg;

  localparam int CFG_W   = 12;
  localparam int TIMER_W = CFG_W;
  localparam int BYTE_W  = 8;

  typedef logic [TIMER_W-1:0] tmr_t;

  localparam tmr_t RECOVER_TICKS = TIMER_W'(15);
  localparam tmr_t RD_LOW_TICKS  = TIMER_W'(5);
  localparam tmr_t RD_WAIT_TICKS = TIMER_W'(15);
  localparam logic [3:0] LAST_BIT = 4'd7;
  localparam logic [BYTE_W-1:0] RX_STUCK = 8'hFF;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_RESET   = 3'd1,
    OP_WR_BIT  = 3'd2,
    OP_RD_BIT  = 3'd3,
    OP_WR_BYTE = 3'd4,
    OP_RD_BYTE = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REC   = 4'd2,
    PH_RST_WATCH = 4'd3,
    PH_WR_LOW    = 4'd4,
    PH_WR_REL    = 4'd5,
    PH_RD_LOW    = 4'd6,
    PH_RD_WAIT   = 4'd7,
    PH_RD_WIN    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRES_WINDOW   = 3'd1,
    REG_PRES_MIN      = 3'd2,
    REG_ZERO_LOW      = 3'd3,
    REG_ONE_LOW       = 3'd4,
    REG_ZERO_RELEASE  = 3'd5,
    REG_ONE_RELEASE   = 3'd6,
    REG_READ_WINDOW   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_time;
    logic [CFG_W-1:0] presence_window;
    logic [CFG_W-1:0] presence_min_width;
    logic [CFG_W-1:0] zero_low_time;
    logic [CFG_W-1:0] one_low_time;
    logic [CFG_W-1:0] zero_release_time;
    logic [CFG_W-1:0] one_release_time;
    logic [CFG_W-1:0] read_window_time;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low_time:     12'd500,
    presence_window:    12'd500,
    presence_min_width: 12'd60,
    zero_low_time:      12'd100,
    one_low_time:       12'd10,
    zero_release_time:  12'd10,
    one_release_time:   12'd150,
    read_window_time:   12'd100
  };

  typedef struct packed {
    logic [2:0]        operation;
    logic [BYTE_W-1:0] tx_data;
    logic              line_level;
  } cmd_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence;
    logic [BYTE_W-1:0] rx_data;
    logic              timed_out;
    logic              rejected;
  } res_t;

endpackage

// File: hdl/owbm_if.sv
interface owbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_data;
  logic       line_level;

  modport source (output valid, output operation, output tx_data, output line_level,
                  input ready);
  modport sink (input valid, input operation, input tx_data, input line_level,
                output ready);
endinterface

interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] rx_data;
  logic       timed_out;
  logic       rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output rx_data, output timed_out, output rejected,
                  input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence, input rx_data, input timed_out, input rejected,
                output ready);
endinterface

interface owbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/one_wire_bus_master.sv
// 1-Wire bus master stepped by microsecond ticks.
// cmd channel: each word is a command (reset with presence detect, write bit,
//   read bit, write byte, read byte; bytes LSB first) or a tick (operation 0)
//   carrying the sampled bus level. A command sent while busy comes back
//   with rejected set and changes nothing.
// res channel: exactly one word per cmd word: pin drive, busy, done,
//   presence, received data, timeout and rejected flags after that word.
// cfg channel: writes the eight 12-bit timing registers by index; always
//   ready, taken at once. Write only while no command runs.
// A result is formed combinationally from its cmd word and registered in the output queue before it is offered.
// Throughput: one cmd word per cycle while the output queue has room; the whole next state of the slot
//   sequencer is formed in one pass from its registers.
// A two-entry output queue sits on the res side: while the receiver stalls,
//   one more cmd word is taken, then cmd.ready drops until a result leaves.
// Reset: bus released, sequencer idle, flags and shifters cleared, timing
//   registers back to their defaults, output queue emptied.
module one_wire_bus_master (
  input  logic      clk,
  input  logic      rst,
  owbm_cmd_if.sink  cmd,
  owbm_res_if.source res,
  owbm_cfg_if.sink  cfg
);

  owbm_pkg::cfg_t cfg_regs;
  owbm_pkg::cmd_t cmd_word;
  owbm_pkg::res_t core_res;
  owbm_pkg::res_t q_res;
  logic           step;
  logic           q_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= owbm_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      case (owbm_pkg::reg_idx_t'(cfg.index))
        owbm_pkg::REG_RESET_LOW:    cfg_regs.reset_low_time     <= cfg.data;
        owbm_pkg::REG_PRES_WINDOW:  cfg_regs.presence_window    <= cfg.data;
        owbm_pkg::REG_PRES_MIN:     cfg_regs.presence_min_width <= cfg.data;
        owbm_pkg::REG_ZERO_LOW:     cfg_regs.zero_low_time      <= cfg.data;
        owbm_pkg::REG_ONE_LOW:      cfg_regs.one_low_time       <= cfg.data;
        owbm_pkg::REG_ZERO_RELEASE: cfg_regs.zero_release_time  <= cfg.data;
        owbm_pkg::REG_ONE_RELEASE:  cfg_regs.one_release_time   <= cfg.data;
        owbm_pkg::REG_READ_WINDOW:  cfg_regs.read_window_time   <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cmd.ready = !q_full;
  assign step      = cmd.valid && !q_full;

  assign cmd_word.operation  = cmd.operation;
  assign cmd_word.tx_data    = cmd.tx_data;
  assign cmd_word.line_level = cmd.line_level;

  owbm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cmd  (cmd_word),
    .cfg  (cfg_regs),
    .res  (core_res)
  );

  owbm_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .din       (core_res),
    .full      (q_full),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .dout      (q_res)
  );

  assign res.drive_low = q_res.drive_low;
  assign res.busy_res  = q_res.busy_res;
  assign res.done_res  = q_res.done_res;
  assign res.presence  = q_res.presence;
  assign res.rx_data   = q_res.rx_data;
  assign res.timed_out = q_res.timed_out;
  assign res.rejected  = q_res.rejected;

endmodule

// File: hdl/owbm_core.sv
module owbm_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  owbm_pkg::cmd_t  cmd,
  input  owbm_pkg::cfg_t  cfg,
  output owbm_pkg::res_t  res
);

  typedef enum logic [1:0] {
    WS_LOW_ENTER = 2'd0,
    WS_LOW_END   = 2'd1,
    WS_REL_END   = 2'd2
  } wstart_t;

  typedef struct packed {
    owbm_pkg::phase_t ph;
    owbm_pkg::tmr_t   tmr;
    logic [7:0]       tx;
    logic [3:0]       bc;
    logic             done;
  } wr_t;

  localparam owbm_pkg::tmr_t TIMER_ONE = owbm_pkg::TIMER_W'(1);

  // Walk past the zero-length parts of the write slots, up to the first timed part or the end of the write.
  function automatic wr_t wr_walk(input wstart_t start, input logic [7:0] tx,
                                  input logic [3:0] bc, input logic bm,
                                  input owbm_pkg::cfg_t c);
    wr_t            r;
    wstart_t        s;
    logic           stop;
    owbm_pkg::tmr_t len;
    r.ph   = owbm_pkg::PH_WR_LOW;
    r.tmr  = '0;
    r.tx   = tx;
    r.bc   = bc;
    r.done = 1'b0;
    s      = start;
    stop   = 1'b0;
    len    = '0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && s == WS_LOW_ENTER) begin
        len = r.tx[0] ? c.one_low_time : c.zero_low_time;
        if (len != '0) begin
          r.ph  = owbm_pkg::PH_WR_LOW;
          r.tmr = len;
          stop  = 1'b1;
        end else begin
          s = WS_LOW_END;
        end
      end
      if (!stop && s == WS_LOW_END) begin
        len = r.tx[0] ? c.one_release_time : c.zero_release_time;
        if (len != '0) begin
          r.ph  = owbm_pkg::PH_WR_REL;
          r.tmr = len;
          stop  = 1'b1;
        end else begin
          s = WS_REL_END;
        end
      end
      if (!stop && s == WS_REL_END) begin
        if (bm && r.bc < owbm_pkg::LAST_BIT) begin
          r.bc = r.bc + 4'd1;
          r.tx = {1'b0, r.tx[7:1]};
          s    = WS_LOW_ENTER;
        end else begin
          r.ph   = owbm_pkg::PH_IDLE;
          r.tmr  = '0;
          r.done = 1'b1;
          stop   = 1'b1;
        end
      end
    end
    return r;
  endfunction

  owbm_pkg::phase_t phase, phase_next;
  owbm_pkg::tmr_t   slot_timer, slot_timer_next;
  logic [7:0]       tx_shift, tx_shift_next;
  logic [7:0]       rx_shift, rx_shift_next;
  logic [3:0]       bit_count, bit_count_next;
  owbm_pkg::tmr_t   low_run, low_run_next;
  logic             low_seen, low_seen_next;
  logic             presence_flag, presence_flag_next;
  logic             timeout_flag, timeout_flag_next;
  logic             byte_mode, byte_mode_next;

  logic    done;
  logic    rej;
  logic    wr_go;
  logic    rd_fin;
  wstart_t wr_start;
  wr_t     wr;

  always_comb begin
    phase_next         = phase;
    slot_timer_next    = slot_timer;
    tx_shift_next      = tx_shift;
    rx_shift_next      = rx_shift;
    bit_count_next     = bit_count;
    low_run_next       = low_run;
    low_seen_next      = low_seen;
    presence_flag_next = presence_flag;
    timeout_flag_next  = timeout_flag;
    byte_mode_next     = byte_mode;
    done     = 1'b0;
    rej      = 1'b0;
    wr_go    = 1'b0;
    rd_fin   = 1'b0;
    wr_start = WS_LOW_ENTER;
    wr       = '0;

    case (owbm_pkg::op_t'(cmd.operation))
      owbm_pkg::OP_TICK: begin
        if (phase != owbm_pkg::PH_IDLE) begin
          if (phase == owbm_pkg::PH_RST_WATCH) begin
            if (!cmd.line_level) begin
              low_seen_next = 1'b1;
              if (low_run != '1) low_run_next = low_run + 1'b1;
            end else if (low_seen) begin
              if (low_run > cfg.presence_min_width) presence_flag_next = 1'b1;
              low_seen_next = 1'b0;
              low_run_next  = '0;
            end
          end else if (phase == owbm_pkg::PH_RD_WAIT && slot_timer == TIMER_ONE) begin
            if (cmd.line_level) rx_shift_next[bit_count[2:0]] = 1'b1;
          end else if (phase == owbm_pkg::PH_RD_WIN && cmd.line_level) begin
            low_seen_next = 1'b0;
          end
          if (slot_timer != '0) slot_timer_next = slot_timer - 1'b1;
          if (slot_timer_next == '0) begin
            case (phase)
              owbm_pkg::PH_RST_LOW: begin
                phase_next      = owbm_pkg::PH_RST_REC;
                slot_timer_next = owbm_pkg::RECOVER_TICKS;
              end
              owbm_pkg::PH_RST_REC: begin
                low_run_next    = '0;
                low_seen_next   = 1'b0;
                phase_next      = owbm_pkg::PH_RST_WATCH;
                slot_timer_next = cfg.presence_window;
                if (cfg.presence_window == '0) begin
                  phase_next = owbm_pkg::PH_IDLE;
                  done       = 1'b1;
                end
              end
              owbm_pkg::PH_WR_LOW: begin
                wr_go    = 1'b1;
                wr_start = WS_LOW_END;
              end
              owbm_pkg::PH_WR_REL: begin
                wr_go    = 1'b1;
                wr_start = WS_REL_END;
              end
              owbm_pkg::PH_RD_LOW: begin
                phase_next      = owbm_pkg::PH_RD_WAIT;
                slot_timer_next = owbm_pkg::RD_WAIT_TICKS;
              end
              owbm_pkg::PH_RD_WAIT: begin
                low_seen_next   = !rx_shift_next[bit_count[2:0]];
                phase_next      = owbm_pkg::PH_RD_WIN;
                slot_timer_next = cfg.read_window_time;
                if (cfg.read_window_time == '0) rd_fin = 1'b1;
              end
              owbm_pkg::PH_RD_WIN: rd_fin = 1'b1;
              default: begin
                // end of the presence watch
                phase_next      = owbm_pkg::PH_IDLE;
                slot_timer_next = '0;
                done            = 1'b1;
              end
            endcase
          end
        end
      end
      owbm_pkg::OP_RESET, owbm_pkg::OP_WR_BIT, owbm_pkg::OP_RD_BIT,
      owbm_pkg::OP_WR_BYTE, owbm_pkg::OP_RD_BYTE: begin
        if (phase != owbm_pkg::PH_IDLE) begin
          rej = 1'b1;
        end else begin
          timeout_flag_next = 1'b0;
          bit_count_next    = '0;
          low_seen_next     = 1'b0;
          low_run_next      = '0;
          byte_mode_next    = cmd.operation == owbm_pkg::OP_WR_BYTE ||
                              cmd.operation == owbm_pkg::OP_RD_BYTE;
          case (owbm_pkg::op_t'(cmd.operation))
            owbm_pkg::OP_RESET: begin
              presence_flag_next = 1'b0;
              phase_next         = owbm_pkg::PH_RST_LOW;
              slot_timer_next    = cfg.reset_low_time;
              if (cfg.reset_low_time == '0) begin
                phase_next      = owbm_pkg::PH_RST_REC;
                slot_timer_next = owbm_pkg::RECOVER_TICKS;
              end
            end
            owbm_pkg::OP_WR_BIT: begin
              tx_shift_next = {7'd0, cmd.tx_data[0]};
              wr_go         = 1'b1;
            end
            owbm_pkg::OP_WR_BYTE: begin
              tx_shift_next = cmd.tx_data;
              wr_go         = 1'b1;
            end
            default: begin
              rx_shift_next   = '0;
              phase_next      = owbm_pkg::PH_RD_LOW;
              slot_timer_next = owbm_pkg::RD_LOW_TICKS;
            end
          endcase
        end
      end
      default: ;
    endcase

    if (rd_fin) begin
      if (low_seen_next) begin
        timeout_flag_next = 1'b1;
        if (byte_mode_next) rx_shift_next[bit_count_next[2:0]] = 1'b1;
        else rx_shift_next = owbm_pkg::RX_STUCK;
      end
      low_seen_next = 1'b0;
      if (byte_mode_next && bit_count_next < owbm_pkg::LAST_BIT) begin
        bit_count_next  = bit_count_next + 4'd1;
        phase_next      = owbm_pkg::PH_RD_LOW;
        slot_timer_next = owbm_pkg::RD_LOW_TICKS;
      end else begin
        phase_next      = owbm_pkg::PH_IDLE;
        slot_timer_next = '0;
        done            = 1'b1;
      end
    end

    if (wr_go) begin
      wr = wr_walk(wr_start, tx_shift_next, bit_count_next, byte_mode_next, cfg);
      phase_next      = wr.ph;
      slot_timer_next = wr.tmr;
      tx_shift_next   = wr.tx;
      bit_count_next  = wr.bc;
      done            = wr.done;
    end

    res.drive_low = phase_next == owbm_pkg::PH_RST_LOW || phase_next == owbm_pkg::PH_WR_LOW ||
                    phase_next == owbm_pkg::PH_RD_LOW;
    res.busy_res  = phase_next != owbm_pkg::PH_IDLE;
    res.done_res  = done;
    res.presence  = presence_flag_next;
    res.rx_data   = rx_shift_next;
    res.timed_out = timeout_flag_next;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owbm_pkg::PH_IDLE;
      slot_timer    <= '0;
      tx_shift      <= '0;
      rx_shift      <= '0;
      bit_count     <= '0;
      low_run       <= '0;
      low_seen      <= 1'b0;
      presence_flag <= 1'b0;
      timeout_flag  <= 1'b0;
      byte_mode     <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      slot_timer    <= slot_timer_next;
      tx_shift      <= tx_shift_next;
      rx_shift      <= rx_shift_next;
      bit_count     <= bit_count_next;
      low_run       <= low_run_next;
      low_seen      <= low_seen_next;
      presence_flag <= presence_flag_next;
      timeout_flag  <= timeout_flag_next;
      byte_mode     <= byte_mode_next;
    end
  end

endmodule

// File: hdl/owbm_out_q.sv
module owbm_out_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  owbm_pkg::res_t din,
  output logic           full,
  output logic           out_valid,
  input  logic           out_ready,
  output owbm_pkg::res_t dout
);

  logic           head_valid;
  logic           skid_valid;
  owbm_pkg::res_t head;
  owbm_pkg::res_t skid;
  logic           pop;

  assign pop       = head_valid && out_ready;
  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign dout      = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !head_valid) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload follows the same moves as the valid bits
  always_ff @(posedge clk) begin
    if (pop || !head_valid) begin
      if (skid_valid) begin
        head <= skid;
        if (push) skid <= din;
      end else begin
        head <= din;
      end
    end else if (push) begin
      skid <= din;
    end
  end

endmodule

// File: hdl/owbm_checker.sv
module owbm_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic       presence,
  input logic [7:0] rx_data,
  input logic       timed_out,
  input logic       rejected
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({drive_low, busy_res, done_res, presence, rx_data, timed_out, rejected}))
    else $error("result word changed while stalled");

  // back-pressure only when results are waiting
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> res_valid && !$past(res_ready))
    else $error("cmd not ready while output queue has room");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res && !drive_low && !rejected)
    else $error("done reported with the command still running");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && (rejected || drive_low) |-> busy_res)
    else $error("rejection or bus drive without a running command");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .drive_low (res.drive_low),
  .busy_res  (res.busy_res),
  .done_res  (res.done_res),
  .presence  (res.presence),
  .rx_data   (res.rx_data),
  .timed_out (res.timed_out),
  .rejected  (res.rejected)
);
